// ----- rtl/core/spdma_pkg.sv -----
// shared constants and types of the scratchpad dma job controller
`timescale 1ns / 1ps
package spdma_pkg;

   localparam int unsigned JobSlotsDefault = 8;

   localparam logic [11:0] OFF_SRC_LO = 12'h000;
   localparam logic [11:0] OFF_SRC_HI = 12'h004;
   localparam logic [11:0] OFF_DST_LO = 12'h008;
   localparam logic [11:0] OFF_DST_HI = 12'h00c;
   localparam logic [11:0] OFF_COUNT  = 12'h010;
   localparam logic [11:0] OFF_TOKEN  = 12'h014;
   localparam logic [11:0] OFF_EID_LO = 12'h018;
   localparam logic [11:0] OFF_EID_HI = 12'h01c;
   localparam logic [11:0] OFF_DIR    = 12'h020;
   localparam logic [11:0] OFF_CMD    = 12'h024;
   localparam logic [11:0] OFF_STATUS = 12'h028;
   localparam logic [11:0] OFF_ERROR  = 12'h02c;

   localparam logic [31:0] CMD_SUBMIT = 32'd1;
   localparam logic [31:0] CMD_WAIT   = 32'd2;

   localparam logic [2:0] ERR_REJECT     = 3'd1;
   localparam logic [2:0] ERR_READ_FAULT = 3'd2;
   localparam logic [2:0] ERR_NO_MATCH   = 3'd3;
   localparam logic [2:0] ERR_WR_FAULT   = 3'd4;
   localparam logic [2:0] ERR_BAD_CMD    = 3'd5;

   localparam logic [3:0] ST_READY    = 4'h1;
   localparam logic [3:0] ST_COMPLETE = 4'h2;
   localparam logic [3:0] ST_ERROR    = 4'h4;
   localparam logic [3:0] ST_BUSY     = 4'h8;

   localparam logic [1:0] EV_NONE   = 2'd0;
   localparam logic [1:0] EV_SUBMIT = 2'd1;
   localparam logic [1:0] EV_WAIT   = 2'd2;

   localparam logic [1:0] CSR_BASE = 2'd0;
   localparam logic [1:0] CSR_SIZE = 2'd1;

   // window check result handed from the checker to the sequencer
   typedef struct packed {
      logic src_in;
      logic dst_in;
      logic fits;
   } win_chk_type;

endpackage

// ----- rtl/core/spdma_window.sv -----
// scratchpad window check: shared subtract and compare unit used over three steps
`timescale 1ns / 1ps
module spdma_window (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [63:0]             base,
   input  logic [24:0]             size,
   input  logic [63:0]             src,
   input  logic [63:0]             dst,
   input  logic [31:0]             count,
   output logic                    done,
   output spdma_pkg::win_chk_type  chk
);
   import spdma_pkg::*;

   logic [1:0]  step_ff, step_in;
   logic [64:0] wsize;
   logic [63:0] room;
   logic [63:0] operand;
   logic [63:0] diff;
   logic        hit;
   logic        src_in_ff, dst_in_ff, fits_ff;
   logic [64:0] left;
   logic        fits;

   // window clipped at the top of the address space
   always_comb begin
      room = 64'd0 - base;
      if (base != 64'd0 && {39'd0, size} > room) wsize = {1'b0, room};
      else wsize = {40'd0, size};
   end

   // one shared subtract and compare
   always_comb begin
      operand = (step_ff == 2'd1) ? dst :
                (step_ff == 2'd2) ? (src_in_ff ? src : dst) : src;
      diff = operand - base;
      hit  = (operand >= base) && ({1'b0, diff} < wsize);
      left = wsize - {1'b0, diff};
      fits = {33'd0, count} <= left;
   end

   always_comb begin
      step_in = step_ff;
      if (start) step_in = 2'd0;
      else if (step_ff != 2'd3) step_in = step_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd3;
      end else begin
         step_ff <= start ? 2'd0 : step_in;
      end
      if (step_ff == 2'd0) src_in_ff <= hit;
      if (step_ff == 2'd1) dst_in_ff <= hit;
      if (step_ff == 2'd2) fits_ff   <= fits;
   end

   assign chk  = {src_in_ff, dst_in_ff, fits_ff};
   assign done = (step_ff == 2'd3);
endmodule

// ----- rtl/core/spdma_table.sv -----
// job table with a slot scan, one slot compared per cycle
`timescale 1ns / 1ps
module spdma_table #(
   parameter int unsigned JOB_SLOTS = spdma_pkg::JobSlotsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 scan_start,
   input  logic [63:0]          key_eid,
   input  logic [31:0]          key_token,
   output logic                 scan_done,
   output logic                 match_found,
   output logic                 free_found,
   output logic [((JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1)-1:0] match_idx,
   output logic [63:0]          match_dst,
   output logic [24:0]          match_len,
   output logic                 any_valid,
   output logic                 any_other,
   input  logic                 ins,
   input  logic [63:0]          ins_dst,
   input  logic [24:0]          ins_len,
   input  logic                 del
);
   import spdma_pkg::*;

   localparam int unsigned IW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;

   logic [JOB_SLOTS-1:0] valid_ff;
   logic [63:0] eid_mem   [JOB_SLOTS];
   logic [31:0] tok_mem   [JOB_SLOTS];
   logic [63:0] dst_mem   [JOB_SLOTS];
   logic [24:0] len_mem   [JOB_SLOTS];
   logic [IW-1:0] ptr_ff;
   logic [IW-1:0] free_ff;
   logic          busy_ff;
   logic          hit;
   logic [JOB_SLOTS-1:0] onehot_m;

   assign hit = valid_ff[ptr_ff] && eid_mem[ptr_ff] == key_eid
                && tok_mem[ptr_ff] == key_token;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         busy_ff     <= 1'b0;
         match_found <= 1'b0;
         free_found  <= 1'b0;
      end else begin
         if (scan_start) begin
            busy_ff     <= 1'b1;
            ptr_ff      <= '0;
            match_found <= 1'b0;
            free_found  <= 1'b0;
         end else if (busy_ff) begin
            if (hit && !match_found) begin
               match_found <= 1'b1;
               match_idx   <= ptr_ff;
               match_dst   <= dst_mem[ptr_ff];
               match_len   <= len_mem[ptr_ff];
            end
            if (!valid_ff[ptr_ff] && !free_found) begin
               free_found <= 1'b1;
               free_ff    <= ptr_ff;
            end
            if (ptr_ff == IW'(JOB_SLOTS - 1)) busy_ff <= 1'b0;
            else ptr_ff <= ptr_ff + IW'(1);
         end
         if (ins) begin
            valid_ff[free_ff] <= 1'b1;
            eid_mem[free_ff]  <= key_eid;
            tok_mem[free_ff]  <= key_token;
            dst_mem[free_ff]  <= ins_dst;
            len_mem[free_ff]  <= ins_len;
         end
         if (del) valid_ff[match_idx] <= 1'b0;
      end
   end

   always_comb begin
      onehot_m = '0;
      onehot_m[match_idx] = 1'b1;
   end

   assign scan_done = !busy_ff && !scan_start;
   assign any_valid = |valid_ff;
   assign any_other = |(valid_ff & ~onehot_m);
endmodule

// ----- rtl/core/scratchpad_dma_job_controller.sv -----
// top level of the scratchpad dma job controller
`timescale 1ns / 1ps
// Register block of a scratchpad DMA engine. Bus accesses arrive as items on
// req_ and each produces exactly one result item on rsp_. Reads and plain
// register writes give their result in the cycle after acceptance. A write to
// the command register starts a sequencer: the job table is scanned one slot
// per cycle while a shared subtract/compare unit checks the scratchpad window
// in three steps; the result is registered once both have finished (state
// S_RUN, then S_RESP). The block takes no new item until the result has been
// taken.
// csr_ writes set the window base (index 0) and size (index 1).
module scratchpad_dma_job_controller #(
   parameter int unsigned JOB_SLOTS = spdma_pkg::JobSlotsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [11:0] req_offset,
   input  logic [31:0] req_write_data,
   input  logic        req_transfer_fault,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic [1:0]  rsp_event_code,
   output logic [63:0] rsp_event_source,
   output logic [63:0] rsp_event_destination,
   output logic [31:0] rsp_event_byte_count,
   output logic [31:0] rsp_event_token,
   output logic [63:0] rsp_event_exec_id,
   output logic [31:0] rsp_event_direction,
   output logic [63:0] rsp_xfer_address,
   output logic [24:0] rsp_xfer_length,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   import spdma_pkg::*;

   localparam int unsigned IW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_RESP} state_type;

   state_type   state_ff;
   logic [63:0] base_ff;
   logic [24:0] size_ff;
   logic [63:0] src_ff, dst_ff, eid_ff;
   logic [31:0] cnt_ff, tok_ff, dir_ff;
   logic [3:0]  status_ff;
   logic [2:0]  error_ff;
   logic [31:0] cmd_ff;
   logic        fault_ff;

   logic        start;
   logic        win_done, scan_done;
   win_chk_type chk;
   logic        match_found, free_found, any_valid, any_other;
   logic [IW-1:0] match_idx;
   logic [63:0] match_dst;
   logic [24:0] match_len;
   logic        ins, del;
   logic        accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign start     = accept && req_kind && req_offset == OFF_CMD;

   spdma_window u_window (
      .clock(clock), .reset(reset), .start(start),
      .base(base_ff), .size(size_ff), .src(src_ff), .dst(dst_ff),
      .count(cnt_ff), .done(win_done), .chk(chk)
   );

   spdma_table #(.JOB_SLOTS(JOB_SLOTS)) u_table (
      .clock(clock), .reset(reset), .scan_start(start),
      .key_eid(eid_ff), .key_token(tok_ff),
      .scan_done(scan_done), .match_found(match_found),
      .free_found(free_found), .match_idx(match_idx),
      .match_dst(match_dst), .match_len(match_len),
      .any_valid(any_valid), .any_other(any_other),
      .ins(ins), .ins_dst(dst_ff), .ins_len(cnt_ff[24:0]), .del(del)
   );

   // command outcome once the scan and the window check have finished
   logic finish;
   logic sub_ok;
   assign finish = (state_ff == S_RUN) && win_done && scan_done;
   assign sub_ok = free_found && !match_found && cnt_ff != 32'd0
                   && (chk.src_in != chk.dst_in) && chk.fits;
   assign ins = finish && cmd_ff == CMD_SUBMIT && sub_ok && !fault_ff;
   assign del = finish && cmd_ff == CMD_WAIT && match_found;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         base_ff   <= 64'h0000_0000_9000_0000;
         size_ff   <= 25'd262144;
         src_ff    <= '0;
         dst_ff    <= '0;
         eid_ff    <= '0;
         cnt_ff    <= '0;
         tok_ff    <= '0;
         dir_ff    <= '0;
         status_ff <= ST_READY;
         error_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_BASE) base_ff <= csr_data;
            else if (csr_index == CSR_SIZE) size_ff <= csr_data[24:0];
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  // defaults: all-zero result
                  rsp_event_code        <= EV_NONE;
                  rsp_event_source      <= '0;
                  rsp_event_destination <= '0;
                  rsp_event_byte_count  <= '0;
                  rsp_event_token       <= '0;
                  rsp_event_exec_id     <= '0;
                  rsp_event_direction   <= '0;
                  rsp_xfer_address      <= '0;
                  rsp_xfer_length       <= '0;
                  cmd_ff   <= req_write_data;
                  fault_ff <= req_transfer_fault;
                  if (!req_kind) begin
                     case (req_offset)
                        OFF_SRC_LO: rsp_read_data <= src_ff[31:0];
                        OFF_SRC_HI: rsp_read_data <= src_ff[63:32];
                        OFF_DST_LO: rsp_read_data <= dst_ff[31:0];
                        OFF_DST_HI: rsp_read_data <= dst_ff[63:32];
                        OFF_COUNT:  rsp_read_data <= cnt_ff;
                        OFF_TOKEN:  rsp_read_data <= tok_ff;
                        OFF_EID_LO: rsp_read_data <= eid_ff[31:0];
                        OFF_EID_HI: rsp_read_data <= eid_ff[63:32];
                        OFF_DIR:    rsp_read_data <= dir_ff;
                        OFF_STATUS: rsp_read_data <= {28'd0, status_ff};
                        OFF_ERROR:  rsp_read_data <= {29'd0, error_ff};
                        default:    rsp_read_data <= '0;
                     endcase
                     state_ff  <= S_RESP;
                     rsp_valid <= 1'b1;
                  end else begin
                     rsp_read_data <= '0;
                     case (req_offset)
                        OFF_SRC_LO: src_ff[31:0]  <= req_write_data;
                        OFF_SRC_HI: src_ff[63:32] <= req_write_data;
                        OFF_DST_LO: dst_ff[31:0]  <= req_write_data;
                        OFF_DST_HI: dst_ff[63:32] <= req_write_data;
                        OFF_COUNT:  cnt_ff <= req_write_data;
                        OFF_TOKEN:  tok_ff <= req_write_data;
                        OFF_EID_LO: eid_ff[31:0]  <= req_write_data;
                        OFF_EID_HI: eid_ff[63:32] <= req_write_data;
                        OFF_DIR:    dir_ff <= req_write_data;
                        default: ;
                     endcase
                     if (req_offset == OFF_CMD) begin
                        state_ff <= S_RUN;
                     end else begin
                        state_ff  <= S_RESP;
                        rsp_valid <= 1'b1;
                     end
                  end
               end
            end
            S_RUN: begin
               if (finish) begin
                  state_ff  <= S_RESP;
                  rsp_valid <= 1'b1;
                  if (cmd_ff == CMD_SUBMIT) begin
                     if (!sub_ok) begin
                        error_ff  <= ERR_REJECT;
                        status_ff <= status_ff | ST_ERROR;
                     end else begin
                        rsp_xfer_address <= src_ff;
                        rsp_xfer_length  <= cnt_ff[24:0];
                        if (fault_ff) begin
                           error_ff  <= ERR_READ_FAULT;
                           status_ff <= status_ff | ST_ERROR;
                        end else begin
                           status_ff             <= ST_READY | ST_BUSY;
                           rsp_event_code        <= EV_SUBMIT;
                           rsp_event_source      <= src_ff;
                           rsp_event_destination <= dst_ff;
                           rsp_event_byte_count  <= cnt_ff;
                           rsp_event_token       <= tok_ff;
                           rsp_event_exec_id     <= eid_ff;
                           rsp_event_direction   <= dir_ff;
                        end
                     end
                  end else if (cmd_ff == CMD_WAIT) begin
                     if (!match_found) begin
                        error_ff  <= ERR_NO_MATCH;
                        status_ff <= status_ff | ST_ERROR;
                     end else begin
                        rsp_event_code        <= EV_WAIT;
                        rsp_event_source      <= src_ff;
                        rsp_event_destination <= dst_ff;
                        rsp_event_byte_count  <= cnt_ff;
                        rsp_event_token       <= tok_ff;
                        rsp_event_exec_id     <= eid_ff;
                        rsp_event_direction   <= dir_ff;
                        rsp_xfer_address      <= match_dst;
                        rsp_xfer_length       <= match_len;
                        if (fault_ff) begin
                           error_ff  <= ERR_WR_FAULT;
                           status_ff <= ST_READY | ST_ERROR;
                        end else begin
                           // busy stays if any other job remains
                           status_ff <= ST_READY | ST_COMPLETE
                                        | (any_other ? ST_BUSY : 4'h0);
                        end
                     end
                  end else begin
                     error_ff  <= ERR_BAD_CMD;
                     status_ff <= ST_READY | ST_ERROR;
                  end
               end
            end
            S_RESP: begin
               if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // result valid only outside idle and run
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_RESP)
      else $error("result valid outside response state");

   // a matched wait always frees a slot that was held
   a_del_valid: assert property (@(posedge clock) disable iff (reset)
      del |-> any_valid)
      else $error("wait removed a job from an empty table");

   // insert and delete never fall in the same cycle
   a_ins_del: assert property (@(posedge clock) disable iff (reset)
      !(ins && del))
      else $error("insert and delete together");

endmodule

// ----- tb/sv/tb.sv -----
// testbench for the scratchpad dma job controller: predictor, driver, monitor and scoreboard
`timescale 1ns / 1ps
module tb;
   import spdma_pkg::*;

   // one bus access as offered on the req_ channel
   typedef struct {
      logic        kind;
      logic [11:0] offset;
      logic [31:0] wdata;
      logic        fault;
   } bus_access_type;

   // one result item as seen on the rsp_ channel
   typedef struct {
      logic [31:0] read_data;
      logic [1:0]  ev_code;
      logic [63:0] ev_src;
      logic [63:0] ev_dst;
      logic [31:0] ev_count;
      logic [31:0] ev_token;
      logic [63:0] ev_eid;
      logic [31:0] ev_dir;
      logic [63:0] xfer_addr;
      logic [24:0] xfer_len;
   } access_result_type;

   localparam int SLOTS = JobSlotsDefault;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_kind;
   logic [11:0] req_offset;
   logic [31:0] req_write_data;
   logic        req_transfer_fault;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_read_data;
   logic [1:0]  rsp_event_code;
   logic [63:0] rsp_event_source;
   logic [63:0] rsp_event_destination;
   logic [31:0] rsp_event_byte_count;
   logic [31:0] rsp_event_token;
   logic [63:0] rsp_event_exec_id;
   logic [31:0] rsp_event_direction;
   logic [63:0] rsp_xfer_address;
   logic [24:0] rsp_xfer_length;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   scratchpad_dma_job_controller DUT (.*);

   // clock with a 12 ns period
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ---------------------------------------------------------------
   // predictor state: window settings, registers and the job table
   // ---------------------------------------------------------------
   logic [63:0] win_base;
   logic [63:0] win_size;
   logic [63:0] src_q, dst_q, eid_q;
   logic [31:0] count_q, token_q, dir_q;
   logic [3:0]  status_q;
   logic [2:0]  error_q;
   logic        job_valid [SLOTS];
   logic [63:0] job_eid   [SLOTS];
   logic [31:0] job_token [SLOTS];
   logic [63:0] job_dst   [SLOTS];
   logic [24:0] job_len   [SLOTS];

   bus_access_type    pending_accesses [$];
   access_result_type expected_results [$];
   int             error_count;
   int             cyc;
   bit             req_taken;
   int             rsp_hold;
   bit             hold_done;

   function automatic void clear_model();
      win_base = 64'h9000_0000;
      win_size = 64'd262144;
      src_q = '0; dst_q = '0; eid_q = '0;
      count_q = '0; token_q = '0; dir_q = '0;
      status_q = ST_READY;
      error_q = '0;
      for (int i = 0; i < SLOTS; i++) job_valid[i] = 1'b0;
   endfunction

   // usable window length, cut off at the top of the address space
   function automatic logic [63:0] usable_size();
      logic [63:0] room;
      room = 64'd0 - win_base;
      if (win_base != 0 && win_size > room) return room;
      return win_size;
   endfunction

   function automatic bit in_window(logic [63:0] a);
      return a >= win_base && (a - win_base) < usable_size();
   endfunction

   function automatic bit request_ok();
      bit s_in, d_in;
      logic [63:0] a;
      s_in = in_window(src_q);
      d_in = in_window(dst_q);
      a = s_in ? src_q : dst_q;
      if (count_q == 0 || s_in == d_in) return 0;
      return {32'd0, count_q} <= usable_size() - (a - win_base);
   endfunction

   function automatic int find_job();
      for (int i = 0; i < SLOTS; i++)
         if (job_valid[i] && job_eid[i] == eid_q && job_token[i] == token_q) return i;
      return -1;
   endfunction

   function automatic int first_free();
      for (int i = 0; i < SLOTS; i++)
         if (!job_valid[i]) return i;
      return -1;
   endfunction

   function automatic bit jobs_left();
      for (int i = 0; i < SLOTS; i++)
         if (job_valid[i]) return 1;
      return 0;
   endfunction

   function automatic void fill_event(ref access_result_type r, input logic [1:0] code);
      r.ev_code  = code;
      r.ev_src   = src_q;
      r.ev_dst   = dst_q;
      r.ev_count = count_q;
      r.ev_token = token_q;
      r.ev_eid   = eid_q;
      r.ev_dir   = dir_q;
   endfunction

   function automatic void run_job_command(logic [31:0] cmd, logic fault,
                                           ref access_result_type r);
      int f, m;
      if (cmd == CMD_SUBMIT) begin
         f = first_free();
         if (f < 0 || find_job() >= 0 || !request_ok()) begin
            error_q = ERR_REJECT;
            status_q |= ST_ERROR;
            return;
         end
         r.xfer_addr = src_q;
         r.xfer_len  = count_q[24:0];
         if (fault) begin
            error_q = ERR_READ_FAULT;
            status_q |= ST_ERROR;
            return;
         end
         job_valid[f] = 1'b1;
         job_eid[f]   = eid_q;
         job_token[f] = token_q;
         job_dst[f]   = dst_q;
         job_len[f]   = count_q[24:0];
         status_q = ST_READY | ST_BUSY;
         fill_event(r, EV_SUBMIT);
      end else if (cmd == CMD_WAIT) begin
         m = find_job();
         if (m < 0) begin
            error_q = ERR_NO_MATCH;
            status_q |= ST_ERROR;
            return;
         end
         fill_event(r, EV_WAIT);
         r.xfer_addr = job_dst[m];
         r.xfer_len  = job_len[m];
         job_valid[m] = 1'b0;
         if (fault) begin
            error_q = ERR_WR_FAULT;
            status_q = ST_READY | ST_ERROR;
            return;
         end
         status_q = ST_READY | ST_COMPLETE | (jobs_left() ? ST_BUSY : 4'h0);
      end else begin
         error_q = ERR_BAD_CMD;
         status_q = ST_READY | ST_ERROR;
      end
   endfunction

   // works out the result of one bus access and updates the register image
   function automatic access_result_type predict_access(bus_access_type a);
      access_result_type r;
      r = '{default: '0};
      if (!a.kind) begin
         case (a.offset)
            OFF_SRC_LO: r.read_data = src_q[31:0];
            OFF_SRC_HI: r.read_data = src_q[63:32];
            OFF_DST_LO: r.read_data = dst_q[31:0];
            OFF_DST_HI: r.read_data = dst_q[63:32];
            OFF_COUNT:  r.read_data = count_q;
            OFF_TOKEN:  r.read_data = token_q;
            OFF_EID_LO: r.read_data = eid_q[31:0];
            OFF_EID_HI: r.read_data = eid_q[63:32];
            OFF_DIR:    r.read_data = dir_q;
            OFF_STATUS: r.read_data = {28'd0, status_q};
            OFF_ERROR:  r.read_data = {29'd0, error_q};
            default:    r.read_data = '0;
         endcase
         return r;
      end
      case (a.offset)
         OFF_SRC_LO: src_q[31:0]  = a.wdata;
         OFF_SRC_HI: src_q[63:32] = a.wdata;
         OFF_DST_LO: dst_q[31:0]  = a.wdata;
         OFF_DST_HI: dst_q[63:32] = a.wdata;
         OFF_COUNT:  count_q = a.wdata;
         OFF_TOKEN:  token_q = a.wdata;
         OFF_EID_LO: eid_q[31:0]  = a.wdata;
         OFF_EID_HI: eid_q[63:32] = a.wdata;
         OFF_DIR:    dir_q = a.wdata;
         OFF_CMD:    run_job_command(a.wdata, a.fault, r);
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   logic [63:0] key_eids [$];
   logic [31:0] key_tokens [$];

   task automatic put(logic kind, logic [11:0] off, logic [31:0] data, logic fault = 1'b0);
      bus_access_type a;
      a.kind = kind; a.offset = off; a.wdata = data; a.fault = fault;
      pending_accesses.push_back(a);
   endtask

   task automatic put64(logic [11:0] lo_off, logic [63:0] v);
      put(1'b1, lo_off, v[31:0]);
      put(1'b1, lo_off + 12'h4, v[63:32]);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] pick_eid();
      case ($urandom_range(0, 3))
         0: return 64'd0;
         1: return 64'hFFFF_FFFF_FFFF_FFFF;
         2: return 64'h0000_0001_8000_0000;
         default: return 64'h1234_5678_9ABC_DEF0;
      endcase
   endfunction

   // register set-up and submit of one job, mostly well formed
   task automatic gen_submit();
      logic [63:0] ws, near, far, tmp, eid;
      logic [31:0] cnt, tok;
      ws = (win_base != 0 && win_size > (64'd0 - win_base)) ? 64'd0 - win_base : win_size;
      if (ws == 64'd0) ws = 64'd1;
      near = win_base + ({$urandom(), $urandom()} % ws);
      if ($urandom_range(0, 3) == 0) near = win_base;
      tmp = ws - (near - win_base);
      cnt = (tmp > 64'd4096) ? $urandom_range(1, 4096) : $urandom_range(1, tmp[31:0]);
      if ($urandom_range(0, 9) == 0) cnt = tmp[31:0];
      if ($urandom_range(0, 14) == 0) cnt = cnt + 1;
      if ($urandom_range(0, 19) == 0) cnt = 0;
      do far = rand64(); while (far >= win_base && far - win_base < ws);
      if ($urandom_range(0, 14) == 0) far = near;
      if ($urandom_range(0, 1)) begin
         tmp = near; near = far; far = tmp;
      end
      eid = pick_eid();
      tok = $urandom_range(0, 3);
      put64(OFF_SRC_LO, near);
      put64(OFF_DST_LO, far);
      put(1'b1, OFF_COUNT, cnt);
      put(1'b1, OFF_TOKEN, tok);
      put64(OFF_EID_LO, eid);
      put(1'b1, OFF_DIR, $urandom());
      put(1'b1, OFF_CMD, CMD_SUBMIT, $urandom_range(0, 9) == 0);
      key_eids.push_back(eid);
      key_tokens.push_back(tok);
   endtask

   task automatic gen_wait();
      int k;
      if (key_eids.size() > 0 && $urandom_range(0, 4) != 0) begin
         k = $urandom_range(0, key_eids.size() - 1);
         put64(OFF_EID_LO, key_eids[k]);
         put(1'b1, OFF_TOKEN, key_tokens[k]);
         key_eids.delete(k);
         key_tokens.delete(k);
      end else begin
         put(1'b1, OFF_TOKEN, $urandom_range(0, 5));
      end
      put(1'b1, OFF_CMD, CMD_WAIT, $urandom_range(0, 7) == 0);
   endtask

   task automatic gen_noise();
      case ($urandom_range(0, 4))
         0: put(1'b0, 12'($urandom_range(0, 11) * 4), 32'h0, 1'($urandom_range(0, 1)));
         1: put(1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)), $urandom(),
                1'($urandom_range(0, 1)));
         2: put(1'b1, OFF_CMD, $urandom_range(0, 1) ? 32'($urandom_range(3, 7)) : $urandom(),
                1'($urandom_range(0, 1)));
         3: put(1'b1, $urandom_range(0, 1) ? OFF_STATUS : OFF_ERROR, $urandom());
         default: put(1'b1, 12'($urandom_range(0, 8) * 4), $urandom(),
                      1'($urandom_range(0, 1)));
      endcase
      put(1'b0, $urandom_range(0, 1) ? OFF_STATUS : OFF_ERROR, 32'h0);
   endtask

   task automatic gen_random(int n_items);
      int target;
      target = pending_accesses.size() + n_items;
      while (pending_accesses.size() < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gen_submit();
            5, 6, 7:       gen_wait();
            default:       gen_noise();
         endcase
      end
   endtask

   // wait for the block to go quiet, then write one window register
   task automatic set_window(logic [1:0] idx, logic [63:0] v);
      @(negedge clock);
      wait (pending_accesses.size() == 0 && !req_valid && expected_results.size() == 0);
      repeat (30) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_BASE) win_base = v;
      else win_size = {39'd0, v[24:0]};
   endtask

   // ---------------------------------------------------------------
   // scoreboard
   // ---------------------------------------------------------------
   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      error_count++;
      $display("mismatch at cycle %0d on %s: got %h, expected %h", cyc, field, got, want);
   endtask

   always @(posedge clock) begin
      access_result_type w;
      cyc <= cyc + 1;
      if (!reset) begin
         // item accepted: advance the predictor
         if (req_valid && req_ready) begin
            expected_results.push_back(predict_access('{req_kind, req_offset,
                                                        req_write_data, req_transfer_fault}));
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", 64'd0, 64'd0);
            end else begin
               w = expected_results.pop_front();
               if (rsp_read_data !== w.read_data)
                  report_mismatch("read_data", 64'(rsp_read_data), 64'(w.read_data));
               if (rsp_event_code !== w.ev_code)
                  report_mismatch("event_code", 64'(rsp_event_code), 64'(w.ev_code));
               if (rsp_event_source !== w.ev_src)
                  report_mismatch("event_source", rsp_event_source, w.ev_src);
               if (rsp_event_destination !== w.ev_dst)
                  report_mismatch("event_destination", rsp_event_destination, w.ev_dst);
               if (rsp_event_byte_count !== w.ev_count)
                  report_mismatch("event_byte_count", 64'(rsp_event_byte_count),
                                  64'(w.ev_count));
               if (rsp_event_token !== w.ev_token)
                  report_mismatch("event_token", 64'(rsp_event_token), 64'(w.ev_token));
               if (rsp_event_exec_id !== w.ev_eid)
                  report_mismatch("event_exec_id", rsp_event_exec_id, w.ev_eid);
               if (rsp_event_direction !== w.ev_dir)
                  report_mismatch("event_direction", 64'(rsp_event_direction),
                                  64'(w.ev_dir));
               if (rsp_xfer_address !== w.xfer_addr)
                  report_mismatch("xfer_address", rsp_xfer_address, w.xfer_addr);
               if (rsp_xfer_length !== w.xfer_len)
                  report_mismatch("xfer_length", 64'(rsp_xfer_length), 64'(w.xfer_len));
            end
         end
      end
   end

   // no idling in a recurring stretch of the cycle count, else idle at random
   function automatic bit idle_now();
      if ((cyc % 4000) < 800) return 0;
      return $urandom_range(0, 99) < 16;
   endfunction

   // item driver: next item offered only once the previous one was taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (pending_accesses.size() > 0 && !idle_now()) begin
            bus_access_type a;
            a = pending_accesses.pop_front();
            req_valid          <= 1'b1;
            req_kind           <= a.kind;
            req_offset         <= a.offset;
            req_write_data     <= a.wdata;
            req_transfer_fault <= a.fault;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result acceptor, with one long hold-off while items are still queued
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!hold_done && cyc >= 200 && pending_accesses.size() > 20) begin
         hold_done = 1'b1;
         rsp_hold = 300;
         rsp_ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !idle_now();
      end
   end

   initial begin
      #50ms;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      error_count = 0;
      cyc = 0;
      rsp_hold = 0;
      hold_done = 1'b0;
      req_taken = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = 1'b0;
      req_offset = '0;
      req_write_data = '0;
      req_transfer_fault = 1'b0;
      rsp_ready = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      clear_model();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset values, ignored writes, every error and both events
      put(1'b0, OFF_STATUS, 0);
      put(1'b0, OFF_ERROR, 0);
      put(1'b1, OFF_STATUS, 32'hFFFF_FFFF);
      put(1'b1, 12'hFFC, 32'hFFFF_FFFF, 1'b1);
      put(1'b0, 12'h002, 0);
      put(1'b1, OFF_CMD, 32'd0);
      put(1'b1, OFF_CMD, 32'hFFFF_FFFF);
      put(1'b1, OFF_CMD, CMD_WAIT);
      put(1'b1, OFF_CMD, CMD_SUBMIT);
      put64(OFF_SRC_LO, 64'h9000_0000);
      put64(OFF_DST_LO, 64'hFFFF_FFFF_FFFF_FFFF);
      put(1'b1, OFF_COUNT, 32'd262144);
      put(1'b1, OFF_CMD, CMD_SUBMIT, 1'b1);
      put(1'b1, OFF_CMD, CMD_SUBMIT);
      put(1'b1, OFF_CMD, CMD_SUBMIT);
      put(1'b0, OFF_STATUS, 0);
      put(1'b1, OFF_CMD, CMD_WAIT);
      put(1'b1, OFF_CMD, CMD_SUBMIT);
      put(1'b1, OFF_CMD, CMD_WAIT, 1'b1);
      put(1'b0, OFF_ERROR, 0);
      put(1'b0, OFF_SRC_HI, 0);
      put(1'b0, OFF_DST_HI, 0);
      gen_random(120);

      set_window(CSR_BASE, 64'd0);
      set_window(CSR_SIZE, 64'd16777216);
      gen_random(100);
      set_window(CSR_BASE, 64'hFFFF_FFFF_FFFF_F000);
      gen_random(100);
      set_window(CSR_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
      set_window(CSR_SIZE, 64'd1);
      gen_random(60);
      set_window(CSR_BASE, rand64());
      set_window(CSR_SIZE, {$urandom(), $urandom()});
      gen_random(100);

      wait (pending_accesses.size() == 0 && !req_valid && expected_results.size() == 0);
      repeat (40) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/spdma_pkg.sv
rtl/core/spdma_window.sv
rtl/core/spdma_table.sv
rtl/core/scratchpad_dma_job_controller.sv
tb/sv/tb.sv
